// ===== rtl/confusion_matrix_accumulator_macros.svh =====
// ----------------------------------------------------------------------------
// confusion_matrix_accumulator_macros
// Assertion macros used by the confusion matrix accumulator counter unit.
// ----------------------------------------------------------------------------
`ifndef CONFUSION_MATRIX_ACCUMULATOR_MACROS_SVH
`define CONFUSION_MATRIX_ACCUMULATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CMA_ASSERT_NOW(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CMA_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants, codes and the command format of the confusion matrix
// accumulator.
// ----------------------------------------------------------------------------
package cma_pkg;

    // defaults of the top level parameters and the queue depth
    localparam int MAX_CLASSES_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int SCORE_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH     = 4;

    // port widths
    localparam int MODE_W  = 2;
    localparam int SCORE_W = 16;
    localparam int LABEL_W = 4;
    localparam int CFG_W   = 5;
    localparam int PRED_W  = 4;
    localparam int COUNT_W = 32;
    localparam int ERR_W   = 2;

    localparam logic [CFG_W-1:0] NUM_CLASSES_RST = 5'd16;

    localparam logic [MODE_W-1:0] MODE_SCORE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_LABEL    = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    typedef struct packed {
        op_t               op;
        logic [PRED_W-1:0] pred;
        err_t              err;
    } cmd_t;

endpackage

// ===== rtl/confusion_matrix_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// confusion_matrix_accumulator
// Streaming argmax classifier scoring with a saturating confusion matrix.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the command queue has room, and
// can give one result per clock while result_ready is high. A command is
// written into the command queue at the edge that accepts its transaction;
// its counter is read into the execute stage as it leaves the queue, and its
// result then goes to the result register. The rate is set by the counter
// memory, which has one read and one write port and does one read-modify-write
// per cycle; updates of the same cell in consecutive commands are forwarded.
// Reset clears the matrix at once through per-cell valid bits, so no clearing
// pass follows reset, and a clear command takes effect as it leaves the queue.
module confusion_matrix_accumulator #(
    parameter int MAX_CLASSES = cma_pkg::MAX_CLASSES_DEF,
    parameter int COUNT_BITS  = cma_pkg::COUNT_BITS_DEF,
    parameter int SCORE_BITS  = cma_pkg::SCORE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [cma_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [cma_pkg::MODE_W-1:0]    mode,
    input  logic [cma_pkg::SCORE_W-1:0]   score,
    input  logic [cma_pkg::LABEL_W-1:0]   true_label,
    input  logic                          last_element,
    input  logic [cma_pkg::LABEL_W-1:0]   read_row,
    input  logic [cma_pkg::LABEL_W-1:0]   read_col,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          result_kind,
    output logic [cma_pkg::PRED_W-1:0]    predicted_class,
    output logic [cma_pkg::COUNT_W-1:0]   count_value,
    output logic [cma_pkg::ERR_W-1:0]     error
);
    import cma_pkg::*;

    localparam int IW    = $clog2(MAX_CLASSES * MAX_CLASSES);
    localparam int CMD_W = $bits(cmd_t);
    localparam int QW    = CMD_W + IW;

    logic          q_full;
    logic          q_push;
    cmd_t          fe_cmd;
    logic [IW-1:0] fe_idx;
    logic          q_pop;
    logic          q_not_empty;
    logic [QW-1:0] q_rdata;
    cmd_t          hd_cmd;
    logic [IW-1:0] hd_idx;

    cma_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .SCORE_BITS  (SCORE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .score        (score),
        .true_label   (true_label),
        .last_element (last_element),
        .read_row     (read_row),
        .read_col     (read_col),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (fe_cmd),
        .q_idx        (fe_idx)
    );

    cma_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     ({fe_cmd, fe_idx}),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty)
    );

    assign {hd_cmd, hd_idx} = q_rdata;

    cma_back #(
        .MAX_CLASSES (MAX_CLASSES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_not_empty),
        .q_cmd           (hd_cmd),
        .q_idx           (hd_idx),
        .q_pop           (q_pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_kind     (result_kind),
        .predicted_class (predicted_class),
        .count_value     (count_value),
        .error           (error)
    );

endmodule

// ===== rtl/cma_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_front
// Accepts transactions, runs the streaming argmax and turns each finished
// sample, read or clear into a command for the counter unit.
// ----------------------------------------------------------------------------
module cma_front #(
    parameter int MAX_CLASSES = cma_pkg::MAX_CLASSES_DEF,
    parameter int SCORE_BITS  = cma_pkg::SCORE_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_write,
    input  logic [cma_pkg::CFG_W-1:0]                    cfg_data,
    input  logic                                         item_valid,
    output logic                                         item_ready,
    input  logic [cma_pkg::MODE_W-1:0]                   mode,
    input  logic [cma_pkg::SCORE_W-1:0]                  score,
    input  logic [cma_pkg::LABEL_W-1:0]                  true_label,
    input  logic                                         last_element,
    input  logic [cma_pkg::LABEL_W-1:0]                  read_row,
    input  logic [cma_pkg::LABEL_W-1:0]                  read_col,
    input  logic                                         q_full,
    output logic                                         q_push,
    output cma_pkg::cmd_t                                q_cmd,
    output logic [$clog2(MAX_CLASSES*MAX_CLASSES)-1:0]   q_idx
);
    import cma_pkg::*;

    localparam int PW = $clog2(MAX_CLASSES + 1);
    localparam int BW = $clog2(MAX_CLASSES);
    localparam int IW = $clog2(MAX_CLASSES * MAX_CLASSES);

    logic [CFG_W-1:0]      num_classes_reg;
    logic [SCORE_BITS-1:0] best_score_reg, best_score_next;
    logic [BW-1:0]         best_index_reg, best_index_next;
    logic [PW-1:0]         position_reg, position_next;
    logic                  overflow_reg, overflow_next;

    logic [PW-1:0]         n_act;
    logic                  accept;
    logic [SCORE_BITS-1:0] score_s;
    logic                  ovf_now;
    logic                  take;
    logic [BW-1:0]         cand_index;
    logic [SCORE_BITS-1:0] cand_score;
    logic                  sample_ovf;
    logic                  label_bad;
    logic                  read_bad;

    // register value clamped to the supported range
    always_comb
    begin
        if (8'(num_classes_reg) < 8'd2)
            n_act = PW'(2);
        else if (8'(num_classes_reg) > 8'(MAX_CLASSES))
            n_act = PW'(MAX_CLASSES);
        else
            n_act = PW'(num_classes_reg);
    end

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;
    assign score_s    = SCORE_BITS'(score);

    // elements beyond the class count skip the argmax and flag an overflow
    assign ovf_now    = (position_reg >= n_act);
    assign take       = !ovf_now && ((position_reg == '0) || (score_s > best_score_reg));
    assign cand_index = take ? BW'(position_reg) : best_index_reg;
    assign cand_score = take ? score_s : best_score_reg;
    assign sample_ovf = overflow_reg || ovf_now;
    assign label_bad  = (8'(true_label) >= 8'(n_act));
    assign read_bad   = (8'(read_row) >= 8'(n_act)) || (8'(read_col) >= 8'(n_act));

    always_comb
    begin
        best_score_next = best_score_reg;
        best_index_next = best_index_reg;
        position_next   = position_reg;
        overflow_next   = overflow_reg;
        if (accept && (mode == MODE_SCORE))
        begin
            if (last_element)
            begin
                best_score_next = '0;
                best_index_next = '0;
                position_next   = '0;
                overflow_next   = 1'b0;
            end
            else
            begin
                best_score_next = cand_score;
                best_index_next = cand_index;
                position_next   = ovf_now ? position_reg : position_reg + PW'(1);
                overflow_next   = sample_ovf;
            end
        end
    end

    always_comb
    begin
        q_push = 1'b0;
        q_cmd  = '0;
        q_idx  = '0;
        unique case (mode)
            MODE_SCORE:
            begin
                q_push     = accept && last_element;
                q_cmd.op   = OP_UPDATE;
                q_cmd.pred = PRED_W'(cand_index);
                if (label_bad)
                    q_cmd.err = ERR_LABEL;
                else if (sample_ovf)
                    q_cmd.err = ERR_OVERFLOW;
                else
                    q_cmd.err = ERR_OK;
                q_idx = IW'(true_label) * IW'(MAX_CLASSES) + IW'(cand_index);
            end
            MODE_READ:
            begin
                q_push    = accept;
                q_cmd.op  = OP_READ;
                q_cmd.err = read_bad ? ERR_LABEL : ERR_OK;
                q_idx     = IW'(read_row) * IW'(MAX_CLASSES) + IW'(read_col);
            end
            MODE_CLEAR:
            begin
                q_push   = accept;
                q_cmd.op = OP_CLEAR;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= NUM_CLASSES_RST;
            best_score_reg  <= '0;
            best_index_reg  <= '0;
            position_reg    <= '0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                num_classes_reg <= cfg_data;
            best_score_reg <= best_score_next;
            best_index_reg <= best_index_next;
            position_reg   <= position_next;
            overflow_reg   <= overflow_next;
        end
    end

endmodule

// ===== rtl/cma_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_queue
// Short command queue between the front end and the counter unit.
// ----------------------------------------------------------------------------
module cma_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cma_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             not_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/cma_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_back
// Counter unit: executes queued commands against the counter memory and
// drives the result register.
// ----------------------------------------------------------------------------
`include "confusion_matrix_accumulator_macros.svh"

module cma_back #(
    parameter int MAX_CLASSES = cma_pkg::MAX_CLASSES_DEF,
    parameter int COUNT_BITS  = cma_pkg::COUNT_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_valid,
    input  cma_pkg::cmd_t                               q_cmd,
    input  logic [$clog2(MAX_CLASSES*MAX_CLASSES)-1:0]  q_idx,
    output logic                                        q_pop,
    output logic                                        result_valid,
    input  logic                                        result_ready,
    output logic                                        result_kind,
    output logic [cma_pkg::PRED_W-1:0]                  predicted_class,
    output logic [cma_pkg::COUNT_W-1:0]                 count_value,
    output logic [cma_pkg::ERR_W-1:0]                   error
);
    import cma_pkg::*;

    localparam int CELLS = MAX_CLASSES * MAX_CLASSES;
    localparam int IW    = $clog2(CELLS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] cell_count_reg [CELLS];
    logic [CELLS-1:0]      cell_valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    // execute stage
    logic                  s2_valid_reg;
    cmd_t                  s2_cmd_reg;
    logic [IW-1:0]         s2_idx_reg;
    logic                  s2_vbit_reg;
    logic                  s2_fwd_reg;
    logic [COUNT_BITS-1:0] s2_fwd_val_reg;

    logic                  result_valid_reg;
    logic                  result_kind_reg;
    logic [PRED_W-1:0]     result_pred_reg;
    logic [COUNT_W-1:0]    result_count_reg;
    logic [ERR_W-1:0]      result_err_reg;

    logic                  s2_done;
    logic                  pop_clear;
    logic                  pop_load;
    logic                  wr;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [COUNT_BITS-1:0] res_count;

    assign s2_done   = s2_valid_reg && (!result_valid_reg || result_ready);
    assign q_pop     = q_valid && (!s2_valid_reg || s2_done);
    assign pop_clear = q_pop && (q_cmd.op == OP_CLEAR);
    assign pop_load  = q_pop && (q_cmd.op != OP_CLEAR);

    // a back-to-back update of the same cell takes the value still being written
    assign cur_count = s2_fwd_reg  ? s2_fwd_val_reg :
                       s2_vbit_reg ? rd_data_reg : '0;
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
    assign wr        = s2_done && (s2_cmd_reg.op == OP_UPDATE) && (s2_cmd_reg.err == ERR_OK);

    always_comb
    begin
        if (s2_cmd_reg.err != ERR_OK)
            res_count = '0;
        else if (s2_cmd_reg.op == OP_UPDATE)
            res_count = inc_count;
        else
            res_count = cur_count;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            cell_count_reg[s2_idx_reg] <= inc_count;
        if (pop_load)
            rd_data_reg <= cell_count_reg[q_idx];
    end

    always_ff @(posedge clk)
    begin
        if (pop_load)
        begin
            s2_cmd_reg     <= q_cmd;
            s2_idx_reg     <= q_idx;
            s2_vbit_reg    <= cell_valid_reg[q_idx];
            s2_fwd_reg     <= wr && (s2_idx_reg == q_idx);
            s2_fwd_val_reg <= inc_count;
        end
        if (s2_done)
        begin
            result_kind_reg  <= (s2_cmd_reg.op == OP_READ) ? KIND_READ : KIND_SAMPLE;
            result_pred_reg  <= s2_cmd_reg.pred;
            result_count_reg <= COUNT_W'(res_count);
            result_err_reg   <= s2_cmd_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg   <= '0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // a clear issued with an older write still wins
            if (pop_clear)
                cell_valid_reg <= '0;
            else if (wr)
                cell_valid_reg[s2_idx_reg] <= 1'b1;

            if (pop_load)
                s2_valid_reg <= 1'b1;
            else if (s2_done)
                s2_valid_reg <= 1'b0;

            if (s2_done)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid    = result_valid_reg;
    assign result_kind     = result_kind_reg;
    assign predicted_class = result_pred_reg;
    assign count_value     = result_count_reg;
    assign error           = result_err_reg;

    `CMA_ASSERT_NEXT(a_clear_empties, clk, rst_n, pop_clear, cell_valid_reg == '0, "clear left valid cells")
    `CMA_ASSERT_NEXT(a_stall_holds, clk, rst_n, s2_valid_reg && !s2_done, s2_valid_reg && $stable(s2_idx_reg) && $stable(s2_cmd_reg), "stalled command changed")
    `CMA_ASSERT_NOW(a_error_zero, clk, rst_n, result_valid && (error != ERR_OK), count_value == '0, "error result with nonzero count")
    `CMA_ASSERT_NOW(a_read_no_pred, clk, rst_n, result_valid && (result_kind == KIND_READ), predicted_class == '0, "read result with prediction")

endmodule

// ===== test/tb_confusion_matrix_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_confusion_matrix_accumulator
// Streams scored samples, counter reads and clears into the accumulator while
// a local argmax and confusion matrix predictor tracks every transaction; each
// result is compared field by field in order, under changing class counts and
// random gaps and stalls on both channels, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_confusion_matrix_accumulator;

    import cma_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int CELL_COUNT      = MAX_CLASSES_DEF * MAX_CLASSES_DEF;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 200;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASE_ITEMS     = 170;

    typedef struct packed {
        logic               kind;
        logic [PRED_W-1:0]  pred;
        logic [COUNT_W-1:0] count;
        err_t               err;
    } result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_W-1:0]     cfg_data;
    logic                 item_valid;
    logic                 item_ready;
    logic [MODE_W-1:0]    mode;
    logic [SCORE_W-1:0]   score;
    logic [LABEL_W-1:0]   true_label;
    logic                 last_element;
    logic [LABEL_W-1:0]   read_row;
    logic [LABEL_W-1:0]   read_col;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic                 result_kind;
    logic [PRED_W-1:0]    predicted_class;
    logic [COUNT_W-1:0]   count_value;
    logic [ERR_W-1:0]     error;

    // predictor state
    logic [CFG_W-1:0]     class_reg;
    logic [SCORE_W-1:0]   run_best;
    int                   run_idx;
    int                   run_pos;
    bit                   run_over;
    logic [COUNT_W-1:0]   cm_count [CELL_COUNT];
    bit                   cm_live [CELL_COUNT];

    result_t              pending_results [$];
    result_t              want;

    int  mismatches    = 0;
    int  items_sent;
    int  samples_seen  = 0;
    int  sample_errors = 0;
    int  reads_seen    = 0;
    int  idle_cycles   = 0;
    int  src_idle_pct;
    int  sink_stall_pct;
    bit  sink_hold_req;
    bit  hold_req_q    = 1'b0;
    int  hold_left     = 0;

    confusion_matrix_accumulator uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .mode            (mode),
        .score           (score),
        .true_label      (true_label),
        .last_element    (last_element),
        .read_row        (read_row),
        .read_col        (read_col),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_kind     (result_kind),
        .predicted_class (predicted_class),
        .count_value     (count_value),
        .error           (error)
    );

    always #1 clk = ~clk;

    function automatic int active_classes();
        if (class_reg < 2) return 2;
        if (class_reg > MAX_CLASSES_DEF) return MAX_CLASSES_DEF;
        return int'(class_reg);
    endfunction

    // advance the argmax and matrix state by one accepted transaction
    function automatic void classify_item(logic [MODE_W-1:0] m, logic [SCORE_W-1:0] s,
                                          logic [LABEL_W-1:0] lbl, logic lst,
                                          logic [LABEL_W-1:0] r, logic [LABEL_W-1:0] c);
        int      n;
        int      idx;
        result_t res;
        n = active_classes();
        res = '0;
        case (m)
            MODE_SCORE:
            begin
                if (run_pos >= n)
                    run_over = 1'b1;
                else
                begin
                    if (run_pos == 0 || s > run_best)
                    begin
                        run_best = s;
                        run_idx  = run_pos;
                    end
                    run_pos++;
                end
                if (lst)
                begin
                    res.kind = KIND_SAMPLE;
                    res.pred = PRED_W'(run_idx);
                    res.err  = ERR_OK;
                    if (lbl >= n)
                        res.err = ERR_LABEL;
                    else if (run_over)
                        res.err = ERR_OVERFLOW;
                    else
                    begin
                        idx = lbl * MAX_CLASSES_DEF + run_idx;
                        if (!cm_live[idx])
                            cm_count[idx] = '0;
                        if (cm_count[idx] != '1)
                            cm_count[idx]++;
                        cm_live[idx] = 1'b1;
                        res.count = cm_count[idx];
                    end
                    run_best = '0;
                    run_idx  = 0;
                    run_pos  = 0;
                    run_over = 1'b0;
                    pending_results.insert(pending_results.size(), res);
                end
            end
            MODE_READ:
            begin
                res.kind = KIND_READ;
                if (r >= n || c >= n)
                    res.err = ERR_LABEL;
                else
                begin
                    res.err = ERR_OK;
                    idx = r * MAX_CLASSES_DEF + c;
                    res.count = cm_live[idx] ? cm_count[idx] : '0;
                end
                pending_results.insert(pending_results.size(), res);
            end
            MODE_CLEAR:
                foreach (cm_live[i])
                    cm_live[i] = 1'b0;
            default:
                ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [COUNT_W-1:0] exp_v,
                                        logic [COUNT_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // output side: stall pattern, long hold-off and in-order result check
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                         $time, result_kind, predicted_class, count_value, error);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", COUNT_W'(want.kind), COUNT_W'(result_kind));
                check_field("predicted_class", COUNT_W'(want.pred), COUNT_W'(predicted_class));
                check_field("count_value", want.count, count_value);
                check_field("error", COUNT_W'(want.err), COUNT_W'(error));
                if (want.kind == KIND_READ)
                    reads_seen++;
                else
                begin
                    samples_seen++;
                    if (want.err != ERR_OK)
                        sample_errors++;
                end
            end
        end
        if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (sink_hold_req && !hold_req_q)
        begin
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= sink_stall_pct);
        hold_req_q <= sink_hold_req;
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [SCORE_W-1:0] s,
                             input logic [LABEL_W-1:0] lbl, input logic lst,
                             input logic [LABEL_W-1:0] r, input logic [LABEL_W-1:0] c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        mode         <= m;
        score        <= s;
        true_label   <= lbl;
        last_element <= lst;
        read_row     <= r;
        read_col     <= c;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        classify_item(m, s, lbl, lst, r, c);
        items_sent++;
    endtask

    task automatic send_element(input logic [SCORE_W-1:0] s, input logic [LABEL_W-1:0] lbl,
                                input logic lst);
        send_item(MODE_SCORE, s, lbl, lst, LABEL_W'($urandom), LABEL_W'($urandom));
    endtask

    task automatic send_read(input logic [LABEL_W-1:0] r, input logic [LABEL_W-1:0] c);
        send_item(MODE_READ, SCORE_W'($urandom), LABEL_W'($urandom), 1'($urandom), r, c);
    endtask

    // wait out everything in flight, then write the class count
    task automatic set_classes(input logic [CFG_W-1:0] v);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        class_reg = v;
        cfg_write <= 1'b0;
    endtask

    function automatic logic [LABEL_W-1:0] pick_index(int n);
        if ($urandom_range(4) != 0)
            return LABEL_W'($urandom_range(n - 1));
        return LABEL_W'($urandom);
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score(int style);
        if (style < 3)
            return SCORE_W'($urandom_range(3));
        if (style == 3)
            return $urandom_range(1) ? '1 : '0;
        return SCORE_W'($urandom);
    endfunction

    // one sample; labels on inner elements are noise, only the last one counts
    task automatic send_sample(input int len, input logic [LABEL_W-1:0] lbl, input int style);
        logic [LABEL_W-1:0] inner;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0)
                send_read(pick_index(active_classes()), pick_index(active_classes()));
            inner = ($urandom_range(3) == 0) ? LABEL_W'($urandom) : lbl;
            send_element(pick_score(style), (i == len - 1) ? lbl : inner, i == len - 1);
        end
    endtask

    task automatic random_items(input int count);
        int start;
        int n;
        int pick;
        int len;
        logic [LABEL_W-1:0] lbl;
        start = items_sent;
        while (items_sent - start < count)
        begin
            n = active_classes();
            pick = $urandom_range(99);
            if (pick < 8)
                send_read(pick_index(n), pick_index(n));
            else if (pick < 10)
                send_item(MODE_CLEAR, SCORE_W'($urandom), LABEL_W'($urandom), 1'($urandom),
                          LABEL_W'($urandom), LABEL_W'($urandom));
            else if (pick < 12)
                send_item(MODE_NONE, SCORE_W'($urandom), LABEL_W'($urandom), 1'($urandom),
                          LABEL_W'($urandom), LABEL_W'($urandom));
            else if (pick < 16)
                send_element(SCORE_W'($urandom), LABEL_W'($urandom), $urandom_range(3) == 0);
            else
            begin
                pick = $urandom_range(19);
                if (pick < 12)
                    len = n;
                else if (pick < 18)
                    len = $urandom_range(n, 1);
                else
                    len = n + $urandom_range(2, 1);
                lbl = ($urandom_range(9) == 0) ? LABEL_W'($urandom)
                                               : LABEL_W'($urandom_range(n - 1));
                send_sample(len, lbl, $urandom_range(9));
            end
        end
    endtask

    task automatic test_reset_state;
        send_read(4'd0, 4'd0);
        send_read(4'd15, 4'd15);
    endtask

    task automatic test_argmax_and_ties;
        set_classes(5'd4);
        // all equal: lowest index wins
        for (int i = 0; i < 4; i++)
            send_element(16'd5, 4'd3, i == 3);
        // largest score on the highest index
        send_element(16'h0000, 4'd0, 1'b0);
        send_element(16'h0000, 4'd0, 1'b0);
        send_element(16'h7FFF, 4'd0, 1'b0);
        send_element(16'hFFFF, 4'd0, 1'b1);
        // single-element sample
        send_element(16'h0000, 4'd1, 1'b1);
    endtask

    task automatic test_error_cases;
        send_element(16'h1234, 4'd4, 1'b1);
        send_element(16'hFFFF, 4'd15, 1'b1);
        // one element more than the class count
        for (int i = 0; i < 5; i++)
            send_element(16'(i * 100), 4'd2, i == 4);
        send_item(MODE_NONE, 16'hFFFF, 4'd15, 1'b1, 4'd15, 4'd15);
    endtask

    task automatic test_read_and_clear;
        send_read(4'd3, 4'd0);
        send_read(4'd4, 4'd0);
        send_read(4'd0, 4'd15);
        send_item(MODE_CLEAR, 16'd0, 4'd0, 1'b0, 4'd0, 4'd0);
        send_read(4'd3, 4'd0);
    endtask

    task automatic test_random_traffic;
        logic [CFG_W-1:0] v;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: v = 5'd2;
                1: v = 5'd16;
                2: v = 5'd0;
                3: v = 5'd31;
                4: v = 5'd7;
                5: v = 5'd17;
                default: v = 5'd1;
            endcase
            set_classes(v);
            case (phase % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 0;
                end
                1:
                begin
                    src_idle_pct   = 46;
                    sink_stall_pct <= 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 46;
                end
                default:
                begin
                    src_idle_pct   = 15;
                    sink_stall_pct <= 15;
                end
            endcase
            random_items(PHASE_ITEMS);
        end
    endtask

    // output held off while input keeps coming, so the block backs up
    task automatic test_backpressure;
        set_classes(5'd3);
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        sink_hold_req <= 1'b1;
        random_items(60);
        sink_hold_req <= 1'b0;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_data       = '0;
        item_valid     = 1'b0;
        mode           = MODE_SCORE;
        score          = '0;
        true_label     = '0;
        last_element   = 1'b0;
        read_row       = '0;
        read_col       = '0;
        class_reg      = NUM_CLASSES_RST;
        run_best       = '0;
        run_idx        = 0;
        run_pos        = 0;
        run_over       = 1'b0;
        foreach (cm_live[i])
        begin
            cm_live[i]  = 1'b0;
            cm_count[i] = '0;
        end
        items_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold_req  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_argmax_and_ties();
        test_error_cases();
        test_read_and_clear();
        test_random_traffic();
        test_backpressure();

        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d transactions, %0d samples (%0d with errors), %0d reads",
                 items_sent, samples_seen, sample_errors, reads_seen);
        $display("class counts 0 to 31, gaps and stalls on both sides, one long output hold-off");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cma_pkg.sv
rtl/cma_front.sv
rtl/cma_queue.sv
rtl/cma_back.sv
rtl/confusion_matrix_accumulator.sv
test/tb_confusion_matrix_accumulator.sv
